// ===== rtl/sfc_pkg.sv =====
// Shared constants, item and result types, and the CRC-16 byte step for the frame checker.
package sfc_pkg;

  localparam logic [4:0]  FRAME_LEN    = 5'd23;
  localparam logic [4:0]  CRC_SPAN     = 5'd21;
  localparam logic [4:0]  COUNT_SAT    = 5'd24;
  localparam logic [4:0]  LAST_POS     = 5'd22;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_TOP      = 16'h8000;
  localparam logic [7:0]  MARKER_RESET = 8'hAA;

  localparam logic [1:0] RES_OK     = 2'd0;
  localparam logic [1:0] RES_LENGTH = 2'd1;
  localparam logic [1:0] RES_START  = 2'd2;
  localparam logic [1:0] RES_CRC    = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } sfc_item_t;

  typedef struct packed {
    logic [1:0]         frame_result;
    logic [7:0]         node_id;
    logic [7:0]         sequence_number;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        vibration;
    logic signed [15:0] tilt_angle;
    logic [15:0]        sensor_flags;
  } sfc_result_t;

  // One byte of CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((a & CRC_TOP) != 16'h0000) begin
        a = {a[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        a = {a[14:0], 1'b0};
      end
    end
    return a;
  endfunction

endpackage

// ===== rtl/sfc_in_stage.sv =====
// Input register: holds one received byte and its last-byte flag.
module sfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              drain,
  input  logic [7:0]        rx_byte,
  input  logic              last_byte,
  output logic              item_valid,
  output sfc_pkg::sfc_item_t item
);
  import sfc_pkg::*;

  logic      valid_r, valid_nxt;
  sfc_item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.rx_byte   <= rx_byte;
      item_r.last_byte <= last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/sfc_frame_core.sv =====
// Frame state: byte count, running CRC, byte store, marker register and the check/unpack logic.
module sfc_frame_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                step,
  input  sfc_pkg::sfc_item_t  item,
  output logic                res_valid,
  output sfc_pkg::sfc_result_t res
);
  import sfc_pkg::*;

  logic [4:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  marker_r;
  logic [7:0]  frame_r [FRAME_LEN];
  logic [1:0]  code;
  logic [4:0]  pos;

  assign pos = count_r;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (item.last_byte) begin
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
    end else begin
      if (pos < COUNT_SAT) begin
        count_nxt = pos + 5'd1;
      end
      if (pos < CRC_SPAN) begin
        crc_nxt = crc_byte(crc_r, item.rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      marker_r <= MARKER_RESET;
    end else begin
      if (step) begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
      end
      if (cfg_we) begin
        marker_r <= cfg_data;
      end
    end
  end

  // Store bytes 0..22; anything past the frame length is dropped.
  always_ff @(posedge clk) begin
    if (step && (pos < FRAME_LEN)) begin
      frame_r[pos] <= item.rx_byte;
    end
  end

  // Byte 22 is the current item; the CRC span ended two bytes earlier.
  always_comb begin
    if (pos != LAST_POS) begin
      code = RES_LENGTH;
    end else if (frame_r[0] != marker_r) begin
      code = RES_START;
    end else if ({frame_r[21], item.rx_byte} != crc_r) begin
      code = RES_CRC;
    end else begin
      code = RES_OK;
    end
  end

  always_comb begin
    res = '0;
    res.frame_result = code;
    if (code == RES_OK) begin
      res.node_id         = frame_r[1];
      res.sequence_number = frame_r[2];
      res.accel_x         = {frame_r[3], frame_r[4]};
      res.accel_y         = {frame_r[5], frame_r[6]};
      res.accel_z         = {frame_r[7], frame_r[8]};
      res.gyro_x          = {frame_r[9], frame_r[10]};
      res.gyro_y          = {frame_r[11], frame_r[12]};
      res.gyro_z          = {frame_r[13], frame_r[14]};
      res.vibration       = {frame_r[15], frame_r[16]};
      res.tilt_angle      = {frame_r[17], frame_r[18]};
      res.sensor_flags    = {frame_r[19], frame_r[20]};
    end
  end

  assign res_valid = step && item.last_byte;

endmodule

// ===== rtl/sfc_out_reg.sv =====
// Result register: holds one finished frame result until the consumer takes it.
module sfc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfc_pkg::sfc_result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 free,
  output sfc_pkg::sfc_result_t res_q
);
  import sfc_pkg::*;

  logic        valid_r, valid_nxt;
  sfc_result_t res_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign res_q     = res_r;

endmodule

// ===== rtl/sensor_frame_check_and_unpack.sv =====
// Top level: checks a received sensor frame (length, start marker, CRC-16) and unpacks its fields.
//
//   port group | direction | handshake          | carries
//   in_*       | input     | in_valid/in_stall  | one frame byte and its last-byte flag
//   out_*      | output    | out_valid/out_stall| check result and unpacked fields, one per frame
//   cfg_*      | input     | cfg_valid/cfg_ready| start marker value
//
// One byte per cycle sustained while in_stall is low; a byte goes input register ->
// CRC/store logic -> result register, and out_valid rises when the result register loads.
// The CRC step is one byte wide, so each byte is folded into the CRC as a whole.
// Synchronous active-low reset clears count, CRC to 0xFFFF and the marker to 0xAA.
// in_stall rises only when a last byte waits on a full, stalled result register.
module sensor_frame_check_and_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_last_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_result,
  output logic [7:0]         out_node_id,
  output logic [7:0]         out_sequence_number,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic [15:0]        out_vibration,
  output logic signed [15:0] out_tilt_angle,
  output logic [15:0]        out_sensor_flags
);
  import sfc_pkg::*;

  logic        s1_valid;
  sfc_item_t   s1_item;
  logic        s1_move;
  logic        take;
  logic        out_free;
  logic        res_valid;
  sfc_result_t res;
  sfc_result_t res_q;

  // A non-last byte never needs the result register, so it always advances.
  assign s1_move  = s1_valid && (!s1_item.last_byte || out_free);
  assign in_stall = s1_valid && !s1_move;
  assign take     = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  sfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .drain      (s1_move),
    .rx_byte    (in_rx_byte),
    .last_byte  (in_last_byte),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  sfc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (s1_move),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  sfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .res_q     (res_q)
  );

  assign out_frame_result    = res_q.frame_result;
  assign out_node_id         = res_q.node_id;
  assign out_sequence_number = res_q.sequence_number;
  assign out_accel_x         = res_q.accel_x;
  assign out_accel_y         = res_q.accel_y;
  assign out_accel_z         = res_q.accel_z;
  assign out_gyro_x          = res_q.gyro_x;
  assign out_gyro_y          = res_q.gyro_y;
  assign out_gyro_z          = res_q.gyro_z;
  assign out_vibration       = res_q.vibration;
  assign out_tilt_angle      = res_q.tilt_angle;
  assign out_sensor_flags    = res_q.sensor_flags;

endmodule
